// File: hdl/gdib_pkg.sv
package gdib_pkg;

  localparam int DEF_RADIUS = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DW         = 32;
  localparam int DIF_W      = 33;
  localparam int PRD_W      = 66;
  localparam int AREA_W     = 67;
  localparam int DVD_W      = 83;
  localparam int ACC_W      = 84;
  localparam int Z_W        = 48;
  localparam int Q_DEPTH    = 2;

  localparam logic signed [Z_W-1:0] FAR_BOUND = 48'sd655360000000;
  localparam logic signed [Z_W-1:0] SAT_MAX   = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] SAT_MIN   = {1'b1, {(Z_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_X = 3'd0,
    CFG_BASE_Y = 3'd1,
    CFG_WXL    = 3'd2,
    CFG_WXH    = 3'd3,
    CFG_WYL    = 3'd4,
    CFG_WYH    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] base_x;
    logic signed [CFG_W-1:0] base_y;
    logic signed [CFG_W-1:0] wxl;
    logic signed [CFG_W-1:0] wxh;
    logic signed [CFG_W-1:0] wyl;
    logic signed [CFG_W-1:0] wyh;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by_coord;
    logic signed [DW-1:0] bz;
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic signed [DW-1:0] cz;
    logic                 hit;
  } item_t;

  typedef struct packed {
    logic triangle_applied;
    logic range_overlaps;
    logic cell_nonempty;
  } res_t;

  function automatic logic signed [Z_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic same;
    same = (&v[ACC_W-1:Z_W-1]) || (~|v[ACC_W-1:Z_W-1]);
    if (same) return v[Z_W-1:0];
    else if (v[ACC_W-1]) return SAT_MIN;
    else return SAT_MAX;
  endfunction

endpackage

// File: hdl/gdib_front.sv
module gdib_front #(
  parameter int RADIUS = gdib_pkg::DEF_RADIUS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gdib_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gdib_pkg::item_t      in_item,
  input  logic                 pop,
  output gdib_pkg::item_t      head,
  output logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] head_idx,
  output logic                 empty
);
  localparam int DIAM  = 2 * RADIUS + 1;
  localparam int CELLS = DIAM * DIAM;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CRD_W = $clog2(DIAM);
  localparam int PTR_W = $clog2(gdib_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(gdib_pkg::Q_DEPTH + 1);

  gdib_pkg::item_t   q_item_r [gdib_pkg::Q_DEPTH];
  logic [IDX_W-1:0]  q_idx_r  [gdib_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r;

  logic signed [gdib_pkg::DIF_W-1:0] ix, iy;
  logic                              in_win, in_grid;
  logic [IDX_W-1:0]                  idx;
  gdib_pkg::item_t                   entry;
  logic                              push;

  always_comb begin
    ix = gdib_pkg::DIF_W'(in_item.ax) - gdib_pkg::DIF_W'(cfg.base_x);
    iy = gdib_pkg::DIF_W'(in_item.ay) - gdib_pkg::DIF_W'(cfg.base_y);
    in_win = (in_item.ax >= gdib_pkg::DW'(cfg.wxl)) && (in_item.ax < gdib_pkg::DW'(cfg.wxh)) &&
             (in_item.ay >= gdib_pkg::DW'(cfg.wyl)) && (in_item.ay < gdib_pkg::DW'(cfg.wyh));
    in_grid = !ix[gdib_pkg::DIF_W-1] && !iy[gdib_pkg::DIF_W-1] &&
              (ix < gdib_pkg::DIF_W'(DIAM)) && (iy < gdib_pkg::DIF_W'(DIAM));
    idx = IDX_W'(IDX_W'(iy[CRD_W-1:0]) * IDX_W'(DIAM) + IDX_W'(ix[CRD_W-1:0]));
    entry = in_item;
    entry.hit = in_win && in_grid;
  end

  assign in_ready = (cnt_r != CNT_W'(gdib_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign push     = in_valid && in_ready;
  assign head     = q_item_r[rp_r];
  assign head_idx = q_idx_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wp_r] <= entry;
      q_idx_r[wp_r]  <= idx;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// File: hdl/gdib_back.sv
module gdib_back #(
  parameter int RADIUS = gdib_pkg::DEF_RADIUS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gdib_pkg::item_t      head,
  input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] head_idx,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gdib_pkg::res_t       out_res
);
  localparam int DIAM  = 2 * RADIUS + 1;
  localparam int CELLS = DIAM * DIAM;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CRD_W = $clog2(DIAM);
  localparam int DIF_W = gdib_pkg::DIF_W;
  localparam int PRD_W = gdib_pkg::PRD_W;
  localparam int AW    = gdib_pkg::AREA_W;
  localparam int NW    = gdib_pkg::DVD_W;
  localparam int TW    = gdib_pkg::ACC_W;
  localparam int ZW    = gdib_pkg::Z_W;
  localparam int DC_W  = $clog2(NW);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_MUL   = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_DFIN  = 12'b000000100000,
    S_MUL2  = 12'b000001000000,
    S_WSET  = 12'b000010000000,
    S_WALK  = 12'b000100000000,
    S_WEND  = 12'b001000000000,
    S_QRD   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  gdib_pkg::item_t           it_r;
  gdib_pkg::res_t            res_r, out_res_r;
  logic                      out_vld_r, emit_r;
  logic [3:0]                cnt_r;
  logic [IDX_W-1:0]          k_r, wk_addr_r;
  logic [CRD_W-1:0]          i_r;
  logic signed [DIF_W-1:0]   dbx_r, dby_r, dbz_r, dcx_r, dcy_r, dcz_r;
  logic signed [PRD_W-1:0]   prod_r;
  logic signed [AW-1:0]      area_r, nx_r, ny_r;
  logic [AW-1:0]             babs_r;
  logic [NW-1:0]             a_r, q_r;
  logic [AW:0]               rem_r;
  logic [DC_W-1:0]           dcnt_r;
  logic                      dsel_r, dneg_r, wk_vld_r;
  logic signed [ZW-1:0]      xdz_r, ydz_r, z_r, lo_q_r, up_q_r;
  logic signed [TW-1:0]      acc_r, row_r;

  logic signed [ZW-1:0]      lo_mem [CELLS];
  logic signed [ZW-1:0]      up_mem [CELLS];

  logic signed [DIF_W-1:0]   ma, mb, ax_e, ay_e;
  logic signed [PRD_W-1:0]   mul_w;
  logic [AW:0]               r2, dif;
  logic signed [TW-1:0]      qv, dx, dy, zs;
  logic signed [NW-1:0]      nsx, nsy;
  logic [IDX_W-1:0]          ra, wa;
  logic                      lo_we, up_we, ld_out;
  logic signed [ZW-1:0]      lo_wd, up_wd;

  assign ax_e = DIF_W'(it_r.ax);
  assign ay_e = DIF_W'(it_r.ay);

  always_comb begin
    case (cnt_r)
      4'd0:    begin ma = dbx_r; mb = dcy_r; end
      4'd1:    begin ma = dcx_r; mb = dby_r; end
      4'd2:    begin ma = dbz_r; mb = dcy_r; end
      4'd3:    begin ma = dcz_r; mb = dby_r; end
      4'd4:    begin ma = dcz_r; mb = dbx_r; end
      4'd5:    begin ma = dbz_r; mb = dcx_r; end
      4'd6:    begin ma = {1'b0, xdz_r[31:0]}; mb = ax_e; end
      4'd7:    begin ma = DIF_W'($signed(xdz_r[ZW-1:32])); mb = ax_e; end
      4'd8:    begin ma = {1'b0, ydz_r[31:0]}; mb = ay_e; end
      4'd9:    begin ma = DIF_W'($signed(ydz_r[ZW-1:32])); mb = ay_e; end
      default: begin ma = dbx_r; mb = dcy_r; end
    endcase
  end
  assign mul_w = PRD_W'(ma) * PRD_W'(mb);

  assign r2  = {rem_r[AW-1:0], a_r[NW-1]};
  assign dif = r2 - {1'b0, babs_r};
  assign qv  = dneg_r ? -TW'({1'b0, q_r}) : TW'({1'b0, q_r});
  assign nsx = {nx_r, 16'd0};
  assign nsy = {ny_r, 16'd0};
  assign dx  = TW'(xdz_r) <<< 16;
  assign dy  = TW'(ydz_r) <<< 16;
  assign zs  = (acc_r >>> 16) + TW'(it_r.az);

  assign pop       = (state_r == S_IDLE) && !empty;
  assign ld_out    = (state_r == S_DONE) && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          case (head.op)
            gdib_pkg::OP_CLEAR: state_nxt = S_CLEAR;
            gdib_pkg::OP_TRI:   state_nxt = S_MUL;
            gdib_pkg::OP_QUERY: state_nxt = head.hit ? S_QRD : S_DONE;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: if (k_r == IDX_W'(CELLS - 1)) state_nxt = emit_r ? S_DONE : S_IDLE;
      S_MUL:   if (cnt_r == 4'd6) state_nxt = S_CHK;
      S_CHK:   state_nxt = (area_r == '0) ? S_DONE : S_DIV;
      S_DIV:   if (dcnt_r == DC_W'(NW - 1)) state_nxt = S_DFIN;
      S_DFIN:  state_nxt = dsel_r ? S_MUL2 : S_DIV;
      S_MUL2:  if (cnt_r == 4'd10) state_nxt = S_WSET;
      S_WSET:  state_nxt = S_WALK;
      S_WALK:  if (k_r == IDX_W'(CELLS - 1)) state_nxt = S_WEND;
      S_WEND:  state_nxt = S_DONE;
      S_QRD:   state_nxt = S_DONE;
      S_DONE:  if (ld_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      k_r       <= '0;
      emit_r    <= 1'b0;
      out_vld_r <= 1'b0;
      wk_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wk_vld_r <= (state_r == S_WALK);
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      if (ld_out) out_vld_r <= 1'b1;
      if (pop && head.op == gdib_pkg::OP_CLEAR) begin
        k_r    <= '0;
        emit_r <= 1'b1;
      end else if (state_r == S_WSET) begin
        k_r <= '0;
      end else if (state_r == S_CLEAR || state_r == S_WALK) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wk_addr_r <= k_r;
    prod_r    <= mul_w;
    if (ld_out) out_res_r <= res_r;
    case (state_r)
      S_IDLE: begin
        res_r <= '0;
        cnt_r <= '0;
        if (pop) begin
          it_r  <= head;
          dbx_r <= DIF_W'(head.bx) - DIF_W'(head.ax);
          dby_r <= DIF_W'(head.by_coord) - DIF_W'(head.ay);
          dbz_r <= DIF_W'(head.bz) - DIF_W'(head.az);
          dcx_r <= DIF_W'(head.cx) - DIF_W'(head.ax);
          dcy_r <= DIF_W'(head.cy) - DIF_W'(head.ay);
          dcz_r <= DIF_W'(head.cz) - DIF_W'(head.az);
        end
      end
      S_MUL: begin
        cnt_r <= cnt_r + 1'b1;
        case (cnt_r)
          4'd1:    area_r <= AW'(prod_r);
          4'd2:    area_r <= area_r - AW'(prod_r);
          4'd3:    nx_r   <= AW'(prod_r);
          4'd4:    nx_r   <= nx_r - AW'(prod_r);
          4'd5:    ny_r   <= AW'(prod_r);
          4'd6:    ny_r   <= ny_r - AW'(prod_r);
          default: ;
        endcase
      end
      S_CHK: begin
        babs_r <= area_r[AW-1] ? AW'(-area_r) : area_r;
        a_r    <= nsx[NW-1] ? NW'(-nsx) : nsx;
        dneg_r <= nx_r[AW-1] ^ area_r[AW-1];
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= '0;
        dsel_r <= 1'b0;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        a_r    <= a_r << 1;
        if (!dif[AW]) begin
          rem_r <= dif;
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= r2;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
      end
      S_DFIN: begin
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= '0;
        acc_r  <= '0;
        cnt_r  <= 4'd6;
        if (!dsel_r) begin
          xdz_r  <= gdib_pkg::sat48(qv);
          a_r    <= nsy[NW-1] ? NW'(-nsy) : nsy;
          dneg_r <= ny_r[AW-1] ^ area_r[AW-1];
          dsel_r <= 1'b1;
        end else begin
          ydz_r <= gdib_pkg::sat48(qv);
        end
      end
      S_MUL2: begin
        cnt_r <= cnt_r + 1'b1;
        case (cnt_r)
          4'd7, 4'd9: acc_r <= acc_r - TW'(prod_r);
          4'd8, 4'd10: acc_r <= acc_r - (TW'(prod_r) <<< 32);
          default: ;
        endcase
      end
      S_WSET: begin
        row_r <= acc_r;
        i_r   <= '0;
      end
      S_WALK: begin
        z_r <= gdib_pkg::sat48(zs);
        if (i_r == CRD_W'(DIAM - 1)) begin
          i_r   <= '0;
          row_r <= row_r + dy;
          acc_r <= row_r + dy;
        end else begin
          i_r   <= i_r + 1'b1;
          acc_r <= acc_r + dx;
        end
      end
      S_WEND: res_r.triangle_applied <= 1'b1;
      S_QRD: begin
        res_r.cell_nonempty  <= (up_q_r >= lo_q_r);
        res_r.range_overlaps <= (up_q_r > ZW'(it_r.az)) && (lo_q_r < ZW'(it_r.bz));
      end
      default: ;
    endcase
  end

  // cell memories: one write port, one registered read port each
  always_comb begin
    ra    = (state_r == S_IDLE) ? head_idx : k_r;
    wa    = (state_r == S_CLEAR) ? k_r : wk_addr_r;
    lo_we = (state_r == S_CLEAR) || (wk_vld_r && !area_r[AW-1] && (z_r > lo_q_r));
    up_we = (state_r == S_CLEAR) || (wk_vld_r && area_r[AW-1] && (z_r < up_q_r));
    lo_wd = (state_r == S_CLEAR) ? -gdib_pkg::FAR_BOUND : z_r;
    up_wd = (state_r == S_CLEAR) ? gdib_pkg::FAR_BOUND : z_r;
  end

  always_ff @(posedge clk) begin
    if (lo_we) lo_mem[wa] <= lo_wd;
    lo_q_r <= lo_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (up_we) up_mem[wa] <= up_wd;
    up_q_r <= up_mem[ra];
  end
endmodule

// File: hdl/grid_depth_interval_buffer.sv
// Depth interval grid of (2*RADIUS+1)^2 cells, each with a 48-bit Q32.16 lower and upper
// bound held in two single-port-write memories. Every input beat yields exactly one output
// beat. After reset the block sweeps both memories to [-1e7, +1e7], one cell per cycle;
// the input queue may fill meanwhile, but no item is worked on until the sweep ends.
// A clear item repeats that sweep. An add-triangle item needs ten products on one 33x33
// multiplier, two 83-step restoring divisions on a shared divider, then a walk over the
// grid at one cell per cycle using incremental plane sums. A query reads the two bounds
// of its cell from the memories and compares them with its depth range. A two-entry
// input queue lets the next beats be taken while an item is at work; the output register
// decouples the result side.
module grid_depth_interval_buffer #(
  parameter int RADIUS = gdib_pkg::DEF_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz (32 bits each)
  input  logic [287:0]                      in_tdata,
  // opcode
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_nonempty, range_overlaps, triangle_applied, 5 zero bits
  output logic [7:0]                        out_tdata,
  input  logic                              cfg_we,
  input  logic [gdib_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdib_pkg::CFG_W-1:0]        cfg_data
);
  localparam int IDX_W = $clog2((2 * RADIUS + 1) * (2 * RADIUS + 1));

  gdib_pkg::cfg_t  cfg_r;
  gdib_pkg::item_t in_item, head;
  gdib_pkg::res_t  res;
  logic [IDX_W-1:0] head_idx;
  logic            q_empty, bk_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gdib_pkg::CFG_BASE_X: cfg_r.base_x <= cfg_data;
        gdib_pkg::CFG_BASE_Y: cfg_r.base_y <= cfg_data;
        gdib_pkg::CFG_WXL:    cfg_r.wxl    <= cfg_data;
        gdib_pkg::CFG_WXH:    cfg_r.wxh    <= cfg_data;
        gdib_pkg::CFG_WYL:    cfg_r.wyl    <= cfg_data;
        gdib_pkg::CFG_WYH:    cfg_r.wyh    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.op       = gdib_pkg::op_t'(in_tuser);
    in_item.ax       = in_tdata[31:0];
    in_item.ay       = in_tdata[63:32];
    in_item.az       = in_tdata[95:64];
    in_item.bx       = in_tdata[127:96];
    in_item.by_coord = in_tdata[159:128];
    in_item.bz       = in_tdata[191:160];
    in_item.cx       = in_tdata[223:192];
    in_item.cy       = in_tdata[255:224];
    in_item.cz       = in_tdata[287:256];
    in_item.hit      = 1'b0;
  end

  gdib_front #(.RADIUS(RADIUS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .pop      (bk_pop),
    .head     (head),
    .head_idx (head_idx),
    .empty    (q_empty)
  );

  gdib_back #(.RADIUS(RADIUS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_idx  (head_idx),
    .empty     (q_empty),
    .pop       (bk_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.triangle_applied, res.range_overlaps, res.cell_nonempty};

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && (out_tdata[0] || out_tdata[1])))
    else $error("triangle and query flags set in one beat");
endmodule

// File: test/grid_depth_interval_buffer_tb.sv
`timescale 1ns / 100ps

module grid_depth_interval_buffer_tb;

  localparam int DIAM  = 2 * gdib_pkg::DEF_RADIUS + 1;
  localparam int CELLS = DIAM * DIAM;
  localparam longint ZMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ZMIN = -ZMAX - 1;
  localparam longint FAR  = 64'sd655360000000;
  localparam int STALL_CYCLES = 3000;

  typedef struct {
    gdib_pkg::op_t op;
    logic [31:0] f [9];
  } grid_cmd_t;

  typedef struct {
    logic nonempty;
    logic overlaps;
    logic applied;
  } grid_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [gdib_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdib_pkg::CFG_W-1:0] cfg_data = '0;

  grid_depth_interval_buffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_cmd_t cmd_queue[$];
  grid_ans_t ans_queue[$];
  grid_cmd_t cmd_on_bus;

  longint lower_b [CELLS];
  longint upper_b [CELLS];
  longint base_x_s, base_y_s, wxl_s, wxh_s, wyl_s, wyh_s;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_go = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int errors = 0;
  int n_results = 0;
  int n_applied = 0;
  int n_hits = 0;
  int n_tri = 0;
  int n_query = 0;

  function automatic longint sat48(logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = ZMAX;
    lo = ZMIN;
    if (v > hi) return ZMAX;
    if (v < lo) return ZMIN;
    return longint'(v);
  endfunction

  function automatic void clear_depths();
    for (int k = 0; k < CELLS; k++) begin
      lower_b[k] = -FAR;
      upper_b[k] = FAR;
    end
  endfunction

  function automatic logic rasterize_tri(grid_cmd_t c);
    longint v [9];
    logic signed [127:0] dbx, dby, dbz, dcx, dcy, dcz, area, nx, ny, xs, ys, t, w;
    longint xdz, ydz, z;
    int k;
    for (int n = 0; n < 9; n++) v[n] = longint'($signed(c.f[n]));
    dbx = v[3] - v[0]; dby = v[4] - v[1]; dbz = v[5] - v[2];
    dcx = v[6] - v[0]; dcy = v[7] - v[1]; dcz = v[8] - v[2];
    area = dbx * dcy - dcx * dby;
    if (area == 0) return 1'b0;
    nx = dbz * dcy - dcz * dby;
    ny = dcz * dbx - dbz * dcx;
    xdz = sat48((nx <<< 16) / area);
    ydz = sat48((ny <<< 16) / area);
    xs = xdz;
    ys = ydz;
    for (int j = 0; j < DIAM; j++) begin
      for (int i = 0; i < DIAM; i++) begin
        w = longint'(i) * 65536 - v[0];
        t = xs * w;
        w = longint'(j) * 65536 - v[1];
        t = t + ys * w;
        w = v[2];
        z = sat48((t >>> 16) + w);
        k = j * DIAM + i;
        if (area > 0) begin
          if (z > lower_b[k]) lower_b[k] = z;
        end else begin
          if (z < upper_b[k]) upper_b[k] = z;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic grid_ans_t predict_grid(grid_cmd_t c);
    grid_ans_t a;
    longint x, y, ix, iy, zl, zh;
    int k;
    a = '{1'b0, 1'b0, 1'b0};
    case (c.op)
      gdib_pkg::OP_CLEAR: clear_depths();
      gdib_pkg::OP_TRI: a.applied = rasterize_tri(c);
      gdib_pkg::OP_QUERY: begin
        x = longint'($signed(c.f[0]));
        y = longint'($signed(c.f[1]));
        zl = longint'($signed(c.f[2]));
        zh = longint'($signed(c.f[5]));
        ix = x - base_x_s;
        iy = y - base_y_s;
        if (x >= wxl_s && x < wxh_s && y >= wyl_s && y < wyh_s &&
            ix >= 0 && ix < DIAM && iy >= 0 && iy < DIAM) begin
          k = int'(iy * DIAM + ix);
          a.nonempty = upper_b[k] >= lower_b[k];
          a.overlaps = upper_b[k] > zl && lower_b[k] < zh;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        ans_queue.push_back(predict_grid(cmd_on_bus));
        if (cmd_on_bus.op == gdib_pkg::OP_TRI) n_tri++;
        if (cmd_on_bus.op == gdib_pkg::OP_QUERY) n_query++;
      end
      if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_on_bus = cmd_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cmd_on_bus.op;
        in_tdata <= {cmd_on_bus.f[8], cmd_on_bus.f[7], cmd_on_bus.f[6], cmd_on_bus.f[5],
                     cmd_on_bus.f[4], cmd_on_bus.f[3], cmd_on_bus.f[2], cmd_on_bus.f[1],
                     cmd_on_bus.f[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_go != stall_seen) begin
      stall_seen <= stall_go;
      stall_left <= STALL_CYCLES;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    grid_ans_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (ans_queue.size() == 0) begin
          $error("unexpected result beat %b", out_tdata);
          errors++;
        end else begin
          e = ans_queue.pop_front();
          if (out_tdata[0] !== e.nonempty) begin
            $error("cell_nonempty exp %b got %b", e.nonempty, out_tdata[0]);
            errors++;
          end
          if (out_tdata[1] !== e.overlaps) begin
            $error("range_overlaps exp %b got %b", e.overlaps, out_tdata[1]);
            errors++;
          end
          if (out_tdata[2] !== e.applied) begin
            $error("triangle_applied exp %b got %b", e.applied, out_tdata[2]);
            errors++;
          end
          if (out_tdata[7:3] !== 5'd0) begin
            $error("pad bits exp 0 got %b", out_tdata[7:3]);
            errors++;
          end
          n_applied += e.applied;
          n_hits += e.nonempty;
        end
      end
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_cfg(gdib_pkg::cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    case (idx)
      gdib_pkg::CFG_BASE_X: base_x_s = longint'($signed(val[15:0]));
      gdib_pkg::CFG_BASE_Y: base_y_s = longint'($signed(val[15:0]));
      gdib_pkg::CFG_WXL:    wxl_s = longint'($signed(val[15:0]));
      gdib_pkg::CFG_WXH:    wxh_s = longint'($signed(val[15:0]));
      gdib_pkg::CFG_WYL:    wyl_s = longint'($signed(val[15:0]));
      default:              wyh_s = longint'($signed(val[15:0]));
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(int bx, int by, int xl, int xh, int yl, int yh);
    write_cfg(gdib_pkg::CFG_BASE_X, bx);
    write_cfg(gdib_pkg::CFG_BASE_Y, by);
    write_cfg(gdib_pkg::CFG_WXL, xl);
    write_cfg(gdib_pkg::CFG_WXH, xh);
    write_cfg(gdib_pkg::CFG_WYL, yl);
    write_cfg(gdib_pkg::CFG_WYH, yh);
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || in_tvalid || ans_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] grid_coord();
    int g;
    if ($urandom_range(9) < 8) begin
      g = $urandom_range(44);
      g = (g - 6) * 65536 + int'($urandom_range(65535));
      return g;
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] depth_val();
    int d;
    if ($urandom_range(9) < 8) begin
      d = int'($urandom_range(131072000));
      return d - 65536000;
    end
    return $urandom;
  endfunction

  function automatic grid_cmd_t make_cmd(gdib_pkg::op_t op, int a0, int a1, int a2, int b0,
                                         int b1, int b2, int c0, int c1, int c2);
    grid_cmd_t c;
    c.op = op;
    c.f = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return c;
  endfunction

  function automatic grid_cmd_t rand_cmd();
    grid_cmd_t c;
    int r, off;
    r = $urandom_range(99);
    for (int n = 0; n < 9; n++) c.f[n] = $urandom;
    if (r < 25) begin
      c.op = gdib_pkg::OP_TRI;
      for (int n = 0; n < 3; n++) begin
        c.f[3*n] = grid_coord();
        c.f[3*n+1] = grid_coord();
        c.f[3*n+2] = depth_val();
      end
      if ($urandom_range(19) == 0) begin
        c.f[6] = c.f[3];
        c.f[7] = c.f[4];
      end
    end else if (r < 33) begin
      c.op = gdib_pkg::OP_CLEAR;
    end else if (r < 36) begin
      c.op = gdib_pkg::OP_NONE;
    end else begin
      c.op = gdib_pkg::OP_QUERY;
      if ($urandom_range(9) > 0) begin
        off = $urandom_range(38);
        c.f[0] = int'(base_x_s) + off - 3;
        off = $urandom_range(38);
        c.f[1] = int'(base_y_s) + off - 3;
        c.f[2] = depth_val();
        c.f[5] = depth_val();
      end
    end
    return c;
  endfunction

  task automatic random_phase(int n_cmds, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < n_cmds; n++) cmd_queue.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    base_x_s = 0; base_y_s = 0; wxl_s = 0; wxh_s = 0; wyl_s = 0; wyh_s = 0;
    clear_depths();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_window(0, 0, 0, 33, 0, 33);
    // directed
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 5, 5, -1, 0, 0, 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 0, 0, 65536, 32 << 16, 0, 65536,
                                 0, 32 << 16, 2 << 16));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 0, 0, 3 << 16, 0, 32 << 16, 3 << 16,
                                 32 << 16, 0, 1 << 16));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2 << 16, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 32, 32, 5 << 16, 0, 0, 6 << 16,
                                 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 33, 0, 0, 0, 0, 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, -1, 3, 0, 0, 0, 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 65536, 65536, 0, 65536, 65536, 5,
                                 9, 9, 9));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 1 << 16, 2 << 16, 0, 2 << 16, 4 << 16, 7,
                                 3 << 16, 6 << 16, 9));
    // near-degenerate with huge depth swing: saturated x slope
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 0, 0, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF,
                                 0, 1, 32'h8000_0000));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_TRI, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 7, 9, 32'h8000_0000, 0, 0,
                                 32'h7FFF_FFFF, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                                 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 7, 9, -1, 0, 0, 1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gdib_pkg::OP_QUERY, 16, 16, 32'h7FFF_FFFF, 0, 0,
                                 32'h7FFF_FFFF, 0, 0, 0));
    drain();

    random_phase(100, 0, 0);
    random_phase(100, 46, 0);

    set_window(-32768, -32768, -32768, 32767, -32768, 32767);
    random_phase(70, 0, 46);

    set_window(32767, 32767, -32768, 32767, -32768, 32767);
    random_phase(60, 38, 38);

    set_window(-10, 5, -5, 20, 0, 30);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_go = stall_go + 1;
    random_phase(100, 0, 0);

    set_window(0, 0, 0, 33, 0, 33);
    random_phase(80, 38, 38);

    $display("covered %0d results: %0d triangles (%0d applied), %0d queries (%0d nonempty)",
             n_results, n_tri, n_applied, n_query, n_hits);
    $display("window settings: grid-aligned, full range at both base extremes, partial overlap");
    if (errors == 0) begin
      $display("[grid_depth_interval_buffer] OK");
    end else begin
      $display("[grid_depth_interval_buffer] ERROR");
    end
    $finish;
  end

  initial begin
    #(12.0 * 8_000_000);
    $display("[grid_depth_interval_buffer] ERROR");
    $finish;
  end

endmodule
